// ===== sv/pfla_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pfla_pkg;

    // Fixed field widths of the block's ports and its free page counter.
    localparam int ADDR_W = 32;
    localparam int CNT_W = 16;
    localparam int FB_W = 28;
    localparam int STAT_W = 2;
    localparam int MODE_W = 2;
    localparam int CFG_IDX_W = 1;

    // Free byte count saturates at this value.
    localparam logic [FB_W-1:0] FB_MAX = 28'h0FFFFFFF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_END = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD_ADDR = 2'd2;

    // Request modes.
    typedef enum logic [MODE_W-1:0] {
        MODE_INIT  = 2'd0,
        MODE_ALLOC = 2'd1,
        MODE_FREE  = 2'd2,
        MODE_QUERY = 2'd3
    } mode_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_EXEC     = 2'd1,
        ST_INIT     = 2'd2,
        ST_INIT_FIN = 2'd3
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec_op;
        logic init_start;
        logic init_step;
        logic init_fin;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mode_is_init;
        logic out_free;
        logic init_more;
    } stat_t;

endpackage

`default_nettype wire

// ===== sv/pfla_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfla_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire pfla_pkg::stat_t stat,
    output pfla_pkg::cmd_t       cmd
);

    pfla_pkg::state_t state_reg;
    pfla_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfla_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_stall = 1'b1;
        case (state_reg)
            pfla_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next = pfla_pkg::ST_EXEC;
                end
            end
            pfla_pkg::ST_EXEC:
            begin
                if (stat.mode_is_init)
                begin
                    cmd.init_start = 1'b1;
                    state_next = pfla_pkg::ST_INIT;
                end
                else if (stat.out_free)
                begin
                    cmd.exec_op = 1'b1;
                    state_next = pfla_pkg::ST_IDLE;
                end
            end
            pfla_pkg::ST_INIT:
            begin
                if (stat.init_more)
                begin
                    cmd.init_step = 1'b1;
                end
                else
                begin
                    state_next = pfla_pkg::ST_INIT_FIN;
                end
            end
            pfla_pkg::ST_INIT_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.init_fin = 1'b1;
                    state_next = pfla_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pfla_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/pfla_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfla_datapath #(
    parameter int MAX_PAGES = 32768,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    input  wire logic [pfla_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pfla_pkg::ADDR_W-1:0]         cfg_data,
    input  wire logic [pfla_pkg::MODE_W-1:0]         mode,
    input  wire logic [pfla_pkg::ADDR_W-1:0]         page_addr,
    input  wire logic                                out_stall,
    output logic                                     out_valid,
    output logic [pfla_pkg::STAT_W-1:0]              status,
    output logic [pfla_pkg::ADDR_W-1:0]              alloc_addr,
    output logic [pfla_pkg::FB_W-1:0]                free_bytes,
    input  wire pfla_pkg::cmd_t                      cmd,
    output pfla_pkg::stat_t                          stat
);

    localparam int IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int SHIFT = $clog2(PAGE_BYTES);
    localparam int AW = pfla_pkg::ADDR_W;
    localparam int CW = pfla_pkg::CNT_W;

    // Configuration registers and the page-aligned base derived from them.
    logic [AW-1:0] start_reg;
    logic [AW-1:0] end_reg;
    logic [AW:0]   base_reg;
    logic [AW:0]   base_next;

    // Free list state.
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic             hv_reg;
    logic             hv_next;
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    cnt_next;
    logic [CW-1:0]    cnt_inc;

    // Init walk position.
    logic [AW+1:0]  p_reg;
    logic [AW+1:0]  p_next;
    logic [IDX_W:0] idx_reg;
    logic [IDX_W:0] idx_next;

    // Captured request.
    pfla_pkg::mode_t    mode_reg;
    logic [AW-1:0]      addr_reg;

    // Link store: each entry holds the next index and its valid bit.
    logic [IDX_W:0]   link_mem [MAX_PAGES];
    logic [IDX_W:0]   rdata_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    logic [IDX_W:0]   mem_wd;

    // Free address check.
    logic [AW:0]      free_off;
    logic [AW:0]      free_pg;
    logic [IDX_W-1:0] free_idx;
    logic             free_bad;

    // Result assembly.
    logic [pfla_pkg::STAT_W-1:0] res_status;
    logic [AW-1:0]               res_addr;
    logic [AW-1:0]               alloc_addr_c;
    logic [AW-1:0]               fb_wide;
    logic                        out_valid_reg;
    logic                        out_load;

    // Base is the written region_start rounded up to a page boundary.
    assign base_next = (({1'b0, cfg_data} + (AW+1)'(PAGE_BYTES - 1)) >> SHIFT) << SHIFT;

    // Configuration writes; the base is loaded together with the start address.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            end_reg <= '0;
            base_reg <= '0;
        end
        else
        begin
            if (cfg_valid && (cfg_index == pfla_pkg::CFG_REGION_START))
            begin
                start_reg <= cfg_data;
                base_reg <= base_next;
            end
            if (cfg_valid && (cfg_index == pfla_pkg::CFG_REGION_END))
            begin
                end_reg <= cfg_data;
            end
        end
    end

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= pfla_pkg::mode_t'(mode);
            addr_reg <= page_addr;
        end
    end

    // Link store, one write and one registered read of the head entry a cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_wa] <= mem_wd;
        end
        rdata_reg <= link_mem[head_reg];
    end

    // Free address checks: alignment, region bounds, page limit.
    assign free_off = {1'b0, addr_reg} - base_reg;
    assign free_pg = free_off >> SHIFT;
    assign free_idx = free_pg[IDX_W-1:0];
    assign free_bad = (addr_reg[SHIFT-1:0] != '0)
                    || (addr_reg < start_reg)
                    || (addr_reg >= end_reg)
                    || (free_pg >= (AW+1)'(MAX_PAGES));

    // Address of the head page and the saturating increment.
    assign alloc_addr_c = base_reg[AW-1:0] + (AW'(head_reg) << SHIFT);
    assign cnt_inc = (cnt_reg == '1) ? cnt_reg : cnt_reg + 1'b1;

    // Next state of the free list for each command.
    always_comb
    begin
        head_next = head_reg;
        hv_next = hv_reg;
        cnt_next = cnt_reg;
        p_next = p_reg;
        idx_next = idx_reg;
        mem_we = 1'b0;
        mem_wa = head_reg;
        mem_wd = {hv_reg, head_reg};
        res_status = pfla_pkg::STAT_OK;
        res_addr = '0;
        if (cmd.init_start)
        begin
            head_next = '0;
            hv_next = 1'b0;
            cnt_next = '0;
            p_next = {1'b0, base_reg};
            idx_next = '0;
        end
        else if (cmd.init_step)
        begin
            mem_we = 1'b1;
            mem_wa = idx_reg[IDX_W-1:0];
            head_next = idx_reg[IDX_W-1:0];
            hv_next = 1'b1;
            cnt_next = cnt_inc;
            p_next = p_reg + (AW+2)'(PAGE_BYTES);
            idx_next = idx_reg + 1'b1;
        end
        else if (cmd.exec_op)
        begin
            case (mode_reg)
                pfla_pkg::MODE_ALLOC:
                begin
                    if (hv_reg)
                    begin
                        res_addr = alloc_addr_c;
                        head_next = rdata_reg[IDX_W-1:0];
                        hv_next = rdata_reg[IDX_W];
                        if (cnt_reg != '0)
                        begin
                            cnt_next = cnt_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        res_status = pfla_pkg::STAT_EMPTY;
                    end
                end
                pfla_pkg::MODE_FREE:
                begin
                    if (free_bad)
                    begin
                        res_status = pfla_pkg::STAT_BAD_ADDR;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        mem_wa = free_idx;
                        head_next = free_idx;
                        hv_next = 1'b1;
                        cnt_next = cnt_inc;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Free list state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            hv_reg <= 1'b0;
            cnt_reg <= '0;
            p_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            hv_reg <= hv_next;
            cnt_reg <= cnt_next;
            p_reg <= p_next;
            idx_reg <= idx_next;
        end
    end

    // Output register: loads the finished result, holds it while stalled.
    assign out_load = cmd.exec_op || cmd.init_fin;
    assign fb_wide = AW'(cnt_next) << SHIFT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status <= res_status;
            alloc_addr <= res_addr;
            if (fb_wide > AW'(pfla_pkg::FB_MAX))
            begin
                free_bytes <= pfla_pkg::FB_MAX;
            end
            else
            begin
                free_bytes <= fb_wide[pfla_pkg::FB_W-1:0];
            end
        end
    end

    assign out_valid = out_valid_reg;

    // Status toward the controller.
    assign stat.mode_is_init = (mode_reg == pfla_pkg::MODE_INIT);
    assign stat.out_free = !out_valid_reg || !out_stall;
    assign stat.init_more = ((p_reg + (AW+2)'(PAGE_BYTES)) <= {2'b00, end_reg})
                          && (idx_reg < (IDX_W+1)'(MAX_PAGES));

endmodule

`default_nettype wire

// ===== sv/page_free_list_allocator.sv =====
// Physical page allocator holding free pages in a LIFO linked list.
// Configuration: write region_start (index 0) and region_end (index 1) on the
// cfg channel while the block is idle; cfg_ready is always high.
// Input channel (in_valid / in_stall) carries mode and page_addr: init builds
// the list from the region's whole pages, up to MAX_PAGES, alloc pops the head
// page, free checks and pushes page_addr, query only reports. Output channel
// (out_valid / out_stall) returns one beat per request: status, alloc_addr,
// free_bytes. Alloc, free and query are accepted in the idle state, then read
// or write the link store and load the output register in the exec state; the
// next request is accepted back in idle. Init walks the region after exec,
// writing one link entry a cycle, one per page pushed, then loads the output.
// The output register holds a beat while out_stall is high; a finished request
// waits in its last step until the register frees, and in_stall stays high.
// Reset empties the list, clears the free count and the region registers; the
// link store is not cleared and needs an init before use.
`timescale 1ns / 1ps
`default_nettype none

module page_free_list_allocator #(
    parameter int MAX_PAGES = 32768,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [pfla_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pfla_pkg::ADDR_W-1:0]    cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [pfla_pkg::MODE_W-1:0]    mode,
    input  wire logic [pfla_pkg::ADDR_W-1:0]    page_addr,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [pfla_pkg::STAT_W-1:0]         status,
    output logic [pfla_pkg::ADDR_W-1:0]         alloc_addr,
    output logic [pfla_pkg::FB_W-1:0]           free_bytes
);

    pfla_pkg::cmd_t  cmd;
    pfla_pkg::stat_t stat;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    pfla_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    pfla_datapath #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mode       (mode),
        .page_addr  (page_addr),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .status     (status),
        .alloc_addr (alloc_addr),
        .free_bytes (free_bytes),
        .cmd        (cmd),
        .stat       (stat)
    );

endmodule

`default_nettype wire

// ===== sv/pfla_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfla_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_stall,
    input wire logic                           out_valid,
    input wire logic                           out_stall,
    input wire logic [pfla_pkg::STAT_W-1:0]    status,
    input wire logic [pfla_pkg::ADDR_W-1:0]    alloc_addr,
    input wire logic [pfla_pkg::FB_W-1:0]      free_bytes
);

    // A stalled result beat holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(alloc_addr) && $stable(free_bytes))
        else $error("stalled result beat changed");

    // One request at a time: the block stalls right after accepting a beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while a request is in flight");

    // A failed request never reports a page address.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != pfla_pkg::STAT_OK) |-> alloc_addr == '0)
        else $error("address reported with an error status");

    // A new result appears only while a request is being worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result produced with no request in flight");

endmodule

bind page_free_list_allocator pfla_checker u_pfla_checker (.*);

`default_nettype wire
